// File: rtl/lsp_pkg.sv
// Shared constants, register indexes and types of the looping sample player.
package lsp_pkg;

   localparam int MAX_FRAMES     = 4096;
   localparam int ADDR_BITS      = $clog2(MAX_FRAMES);
   localparam int POS_BITS       = 13;
   localparam int TIME_BITS      = 48;
   localparam int SAMPLE_BITS    = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 48;

   localparam logic [TIME_BITS-1:0] TIME_NEVER = {TIME_BITS{1'b1}};
   localparam logic [POS_BITS-1:0]  LEN_MAX    = POS_BITS'(MAX_FRAMES);

   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_RENDER = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_START_FRAME    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_START_POSITION = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STOP_FRAME     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOOP_ENABLE    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOOP_BEGIN     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOOP_FINISH    = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BUFFER_LENGTH  = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEREO         = 3'd7;

   typedef struct packed {
      logic [TIME_BITS-1:0] start_frame;
      logic [TIME_BITS-1:0] stop_frame;
      logic                 loop_enable;
      logic [POS_BITS-1:0]  loop_begin;
      logic [POS_BITS-1:0]  loop_finish;
      logic [POS_BITS-1:0]  buffer_length;
      logic                 stereo;
   } cfg_type;

   typedef struct packed {
      logic                en;
      logic [POS_BITS-1:0] value;
   } pos_load_type;

   typedef struct packed {
      logic valid;
      logic playing;
      logic ended_event;
      logic stereo;
   } stage_type;

endpackage

// File: rtl/lsp_csr.sv
// Configuration registers and play position load strobe.
module lsp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [lsp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lsp_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output lsp_pkg::cfg_type                    cfg,
   output lsp_pkg::pos_load_type               pos_load
);
   import lsp_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_START_FRAME:    cfg_in.start_frame   = csr_wdata[TIME_BITS-1:0];
            REG_START_POSITION: ;
            REG_STOP_FRAME:     cfg_in.stop_frame    = csr_wdata[TIME_BITS-1:0];
            REG_LOOP_ENABLE:    cfg_in.loop_enable   = csr_wdata[0];
            REG_LOOP_BEGIN:     cfg_in.loop_begin    = csr_wdata[POS_BITS-1:0];
            REG_LOOP_FINISH:    cfg_in.loop_finish   = csr_wdata[POS_BITS-1:0];
            REG_BUFFER_LENGTH:  cfg_in.buffer_length = csr_wdata[POS_BITS-1:0];
            REG_STEREO:         cfg_in.stereo        = csr_wdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_frame   <= '0;
         cfg_ff.stop_frame    <= TIME_NEVER;
         cfg_ff.loop_enable   <= 1'b0;
         cfg_ff.loop_begin    <= '0;
         cfg_ff.loop_finish   <= '0;
         cfg_ff.buffer_length <= '0;
         cfg_ff.stereo        <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg            = cfg_ff;
   assign pos_load.en    = csr_write && (csr_index == REG_START_POSITION);
   assign pos_load.value = csr_wdata[POS_BITS-1:0];

endmodule

// File: rtl/lsp_store.sv
// Left and right sample memories with registered read data.
module lsp_store (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [lsp_pkg::ADDR_BITS-1:0]    wr_addr,
   input  logic [lsp_pkg::SAMPLE_BITS-1:0]  wr_left,
   input  logic [lsp_pkg::SAMPLE_BITS-1:0]  wr_right,
   input  logic                             rd_en,
   input  logic [lsp_pkg::ADDR_BITS-1:0]    rd_addr,
   output logic [lsp_pkg::SAMPLE_BITS-1:0]  rd_left,
   output logic [lsp_pkg::SAMPLE_BITS-1:0]  rd_right
);
   import lsp_pkg::*;

   logic [SAMPLE_BITS-1:0] left_store_ff  [MAX_FRAMES];
   logic [SAMPLE_BITS-1:0] right_store_ff [MAX_FRAMES];
   logic [SAMPLE_BITS-1:0] left_rd_ff, right_rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         left_store_ff[wr_addr]  <= wr_left;
         right_store_ff[wr_addr] <= wr_right;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         left_rd_ff  <= left_store_ff[rd_addr];
         right_rd_ff <= right_store_ff[rd_addr];
      end
   end

   assign rd_left  = left_rd_ff;
   assign rd_right = right_rd_ff;

endmodule

// File: rtl/lsp_play.sv
// Play position, ended flag, per-frame decision and the read stage control.
module lsp_play (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept_render,
   input  logic [lsp_pkg::TIME_BITS-1:0]   frame_time,
   input  lsp_pkg::cfg_type                cfg,
   input  lsp_pkg::pos_load_type           pos_load,
   input  logic                            drain,
   output lsp_pkg::stage_type              stage,
   output logic                            rd_en,
   output logic [lsp_pkg::ADDR_BITS-1:0]   rd_addr
);
   import lsp_pkg::*;

   logic [POS_BITS-1:0] position_ff, position_in;
   logic                ended_ff, ended_in;
   stage_type           stage_ff, stage_in;

   logic [POS_BITS-1:0] len, lb, le, le_raw, pos_eff, pos_inc, pos_next;
   logic                at_end, play_now, end_now;

   assign len    = (cfg.buffer_length > LEN_MAX) ? LEN_MAX : cfg.buffer_length;
   assign lb     = cfg.loop_enable ? ((cfg.loop_begin < len) ? cfg.loop_begin : len) : '0;
   assign le_raw = (cfg.loop_finish == '0) ? len :
                   ((cfg.loop_finish < len) ? cfg.loop_finish : len);
   assign le     = (cfg.loop_enable && (le_raw > lb)) ? le_raw : len;

   assign at_end   = (position_ff >= len);
   assign pos_eff  = at_end ? lb : position_ff;
   assign pos_inc  = pos_eff + POS_BITS'(1);
   assign pos_next = (cfg.loop_enable && (pos_inc >= le)) ? lb : pos_inc;

   always_comb begin
      position_in = position_ff;
      ended_in    = ended_ff;
      play_now    = 1'b0;
      end_now     = 1'b0;
      if (pos_load.en) begin
         position_in = pos_load.value;
      end else if (accept_render) begin
         if (ended_ff || (len == '0)) begin
            // silent, no change
         end else if (frame_time < cfg.start_frame) begin
            // not started yet
         end else if ((cfg.stop_frame != TIME_NEVER) && (frame_time >= cfg.stop_frame)) begin
            end_now  = 1'b1;
            ended_in = 1'b1;
         end else if (at_end && !cfg.loop_enable) begin
            end_now  = 1'b1;
            ended_in = 1'b1;
         end else if (pos_eff >= len) begin
            position_in = lb;
         end else begin
            play_now    = 1'b1;
            position_in = pos_next;
         end
      end
   end

   always_comb begin
      stage_in = stage_ff;
      if (accept_render) begin
         stage_in.valid       = 1'b1;
         stage_in.playing     = play_now;
         stage_in.ended_event = end_now;
         stage_in.stereo      = cfg.stereo;
      end else if (drain) begin
         stage_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         ended_ff    <= 1'b0;
         stage_ff    <= '0;
      end else begin
         position_ff <= position_in;
         ended_ff    <= ended_in;
         stage_ff    <= stage_in;
      end
   end

   assign stage   = stage_ff;
   assign rd_en   = accept_render && play_now;
   assign rd_addr = pos_eff[ADDR_BITS-1:0];

   a_ended_sticky: assert property (@(posedge clock) disable iff (reset)
      ended_ff |=> ended_ff)
      else $error("ended flag cleared without reset");

   a_ended_silent: assert property (@(posedge clock) disable iff (reset)
      accept_render && ended_ff |=> !stage_ff.playing && !stage_ff.ended_event)
      else $error("frame after end was not silent");

endmodule

// File: rtl/looping_sample_player_top.sv
// Looping sample player: a render item gives its frame via the read stage and the result register.
// One item (write or render) is accepted every cycle while the result side keeps up;
// the read stage and the result register absorb a stall of the result channel.
// Writes give no result. Reset clears position, ended flag, registers and pipeline
// valids; the sample stores are not cleared and read as undefined until written.
module looping_sample_player_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic [11:0]                         req_address,
   input  logic [31:0]                         req_left_word,
   input  logic [31:0]                         req_right_word,
   input  logic [47:0]                         req_frame_time,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [31:0]                         rsp_left_sample,
   output logic [31:0]                         rsp_right_sample,
   output logic                                rsp_playing,
   output logic                                rsp_ended_event,
   input  logic                                csr_write,
   input  logic [lsp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lsp_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import lsp_pkg::*;

   cfg_type                cfg;
   pos_load_type           pos_load;
   stage_type              stage;
   logic                   accept, accept_render, accept_write, drain;
   logic                   rd_en;
   logic [ADDR_BITS-1:0]   rd_addr;
   logic [SAMPLE_BITS-1:0] rd_left, rd_right;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] left_ff, left_in, right_ff, right_in;
   logic                   playing_ff, playing_in, event_ff, event_in;

   assign req_stall     = stage.valid && rsp_valid_ff && rsp_stall;
   assign accept        = req_valid && !req_stall;
   assign accept_render = accept && (req_kind == KIND_RENDER);
   assign accept_write  = accept && (req_kind == KIND_WRITE);
   assign drain         = stage.valid && (!rsp_valid_ff || !rsp_stall);

   lsp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .pos_load  (pos_load)
   );

   lsp_play u_play (
      .clock         (clock),
      .reset         (reset),
      .accept_render (accept_render),
      .frame_time    (req_frame_time),
      .cfg           (cfg),
      .pos_load      (pos_load),
      .drain         (drain),
      .stage         (stage),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr)
   );

   lsp_store u_store (
      .clock    (clock),
      .wr_en    (accept_write),
      .wr_addr  (req_address[ADDR_BITS-1:0]),
      .wr_left  (req_left_word[SAMPLE_BITS-1:0]),
      .wr_right (req_right_word[SAMPLE_BITS-1:0]),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_left  (rd_left),
      .rd_right (rd_right)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      left_in      = left_ff;
      right_in     = right_ff;
      playing_in   = playing_ff;
      event_in     = event_ff;
      if (drain) begin
         rsp_valid_in = 1'b1;
         left_in      = stage.playing ? rd_left : '0;
         right_in     = stage.playing ? (stage.stereo ? rd_right : rd_left) : '0;
         playing_in   = stage.playing;
         event_in     = stage.ended_event;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff    <= left_in;
      right_ff   <= right_in;
      playing_ff <= playing_in;
      event_ff   <= event_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_sample  = left_ff;
   assign rsp_right_sample = right_ff;
   assign rsp_playing      = playing_ff;
   assign rsp_ended_event  = event_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && stage.valid)
      else $error("input stalled with room in the pipeline");

   a_event_not_playing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(playing_ff && event_ff))
      else $error("ended event on a playing frame");

   a_silent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !playing_ff |-> (left_ff == '0) && (right_ff == '0))
      else $error("silent frame carries sample data");

endmodule
